// ===== sv/psll_pkg.sv =====
// shared types and constants for the per-symbol linked list index
package psll_pkg;

  localparam int unsigned WINDOW_SIZE  = 4096;
  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned POS_W        = $clog2(WINDOW_SIZE);
  localparam int unsigned SYM_W        = $clog2(SYMBOL_COUNT);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FIX
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } link_t;

  typedef struct packed {
    logic              req_type;
    logic [SYM_W-1:0]  symbol;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic              head_valid;
    logic [POS_W-1:0]  head_position;
  } rsp_t;

endpackage

// ===== sv/per_symbol_linked_list_index.sv =====
// per-symbol doubly linked list index over window positions
// an input transfer reaches the earliest result transfer through the memory read registers
//   and then the output register; the update waits while a stalled result holds that register
// a new request is taken only once the last is done; an insert into a non-empty list adds
//   a fix-up state, as the single write port of the previous-link memory is written twice
// reset: head valid bits clear at once, so every list starts empty; no clearing pass,
//   link memories are read on each request, but their contents are used only by deletes
module per_symbol_linked_list_index (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  psll_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output psll_pkg::rsp_t out_data_o
);
  import psll_pkg::*;

  // state and captured request
  state_e            state_q, state_d;
  req_t              req_q;
  logic [POS_W-1:0]  fix_idx_q, fix_idx_d;
  logic              accept;

  // memories
  logic [POS_W-1:0]  head_mem [SYMBOL_COUNT];
  link_t             prev_mem [WINDOW_SIZE];
  link_t             next_mem [WINDOW_SIZE];
  logic [SYMBOL_COUNT-1:0] head_vld_q;

  logic [POS_W-1:0]  head_rd_q;
  link_t             prev_rd_q, next_rd_q;

  // write controls
  logic              head_we;
  logic              head_wr_valid;
  logic [POS_W-1:0]  head_wr_pos;
  logic              prev_we, next_we;
  logic [POS_W-1:0]  prev_wa, next_wa;
  link_t             prev_wd, next_wd;

  // output register
  logic              out_valid_q;
  rsp_t              out_q;
  logic              out_load;
  rsp_t              out_d;

  link_t             head_link;
  logic              out_free;
  logic              is_head;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign head_link  = '{valid: head_vld_q[req_q.symbol], pos: head_rd_q};
  assign is_head    = head_link.valid && (head_link.pos == req_q.position);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        if (out_free) begin
          if (req_q.req_type == REQ_INSERT && head_link.valid) state_d = ST_FIX;
          else state_d = ST_IDLE;
        end
      end
      ST_FIX: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory updates and result
  always_comb begin
    head_we       = 1'b0;
    head_wr_valid = 1'b0;
    head_wr_pos   = req_q.position;
    prev_we       = 1'b0;
    prev_wa       = req_q.position;
    prev_wd       = '0;
    next_we       = 1'b0;
    next_wa       = req_q.position;
    next_wd       = '0;
    out_load      = 1'b0;
    out_d         = '0;
    fix_idx_d     = fix_idx_q;
    case (state_q)
      ST_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          if (req_q.req_type == REQ_INSERT) begin
            // new node at head, old head fixed up next cycle
            head_we       = 1'b1;
            head_wr_valid = 1'b1;
            head_wr_pos   = req_q.position;
            prev_we       = 1'b1;
            prev_wa       = req_q.position;
            prev_wd       = '0;
            next_we       = 1'b1;
            next_wa       = req_q.position;
            next_wd       = head_link;
            fix_idx_d     = head_link.pos;
            out_d         = '{head_valid: 1'b1, head_position: req_q.position};
          end else if (is_head) begin
            // unlink the head: its successor takes over
            head_we       = 1'b1;
            head_wr_valid = next_rd_q.valid;
            head_wr_pos   = next_rd_q.pos;
            prev_we       = next_rd_q.valid;
            prev_wa       = next_rd_q.pos;
            prev_wd       = '0;
            out_d.head_valid    = next_rd_q.valid;
            out_d.head_position = next_rd_q.valid ? next_rd_q.pos : '0;
          end else begin
            // unlink an inner node, head unchanged
            next_we = prev_rd_q.valid;
            next_wa = prev_rd_q.pos;
            next_wd = next_rd_q;
            prev_we = next_rd_q.valid;
            prev_wa = next_rd_q.pos;
            prev_wd = prev_rd_q;
            out_d.head_valid    = head_link.valid;
            out_d.head_position = head_link.valid ? head_link.pos : '0;
          end
        end
      end
      ST_FIX: begin
        prev_we = 1'b1;
        prev_wa = fix_idx_q;
        prev_wd = '{valid: 1'b1, pos: req_q.position};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (head_we) head_vld_q[req_q.symbol] <= head_wr_valid;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    fix_idx_q <= fix_idx_d;
    if (out_load) out_q <= out_d;
  end

  // head position memory
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[req_q.symbol] <= head_wr_pos;
    if (accept) head_rd_q <= head_mem[in_data_i.symbol];
  end

  // previous link memory
  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (accept) prev_rd_q <= prev_mem[in_data_i.position];
  end

  // next link memory
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (accept) next_rd_q <= next_mem[in_data_i.position];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
